/* rtl/flc_pkg.sv */
// ----------------------------------------------------------------------------
// flc_pkg
// Shared widths, constants, register codes and types of the fader level
// conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

    localparam int unsigned RAW_W     = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LEVEL_W   = 10;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned IVL_W     = 20;
    localparam int unsigned THR_W     = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = IVL_W;

    localparam int unsigned LEVEL_SHIFT = 6;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 10'd8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1015;
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;

    // level * 100 / 1015 as level * ceil(100 * 2^27 / 1015) >> 27, exact over 0..1023
    localparam int unsigned PCT_PROD_W = 34;
    localparam int unsigned PCT_SHIFT  = 27;
    localparam logic [23:0] PCT_RECIP  = 24'd13223422;

    localparam logic [IVL_W-1:0] IVL_RESET = 20'd10000;
    localparam logic [THR_W-1:0] THR_RESET = 6'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL  = 1'b0,
        REG_THRESHOLD = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [IVL_W-1:0] interval;
        logic [THR_W-1:0] threshold;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  now_us;
        logic [LEVEL_W-1:0] level;
        logic [PCT_W-1:0]   percent;
    } t_s1_word;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        logic [LEVEL_W-1:0] r;
        if (v < LEVEL_MIN) begin
            r = LEVEL_MIN;
        end else if (v > LEVEL_MAX) begin
            r = LEVEL_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/flc_intf.sv */
// ----------------------------------------------------------------------------
// flc_intf
// Handshake channels of the fader level conditioner: sample input, percent
// output and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface flc_in_if;
    import flc_pkg::*;
    logic              valid;
    logic              ready;
    logic [RAW_W-1:0]  raw_sample;
    logic [TIME_W-1:0] now_us;
    modport source (output valid, output raw_sample, output now_us, input ready);
    modport sink   (input valid, input raw_sample, input now_us, output ready);
endinterface

interface flc_out_if;
    import flc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] fader_percent;
    modport source (output valid, output fader_percent, input ready);
    modport sink   (input valid, input fader_percent, output ready);
endinterface

interface flc_cfg_if;
    import flc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/flc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// flc_cfg_regs
// Update interval and jitter threshold registers with their write decode.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [flc_pkg::CFG_IDX_W-1:0] i_index,
    input  wire logic [flc_pkg::CFG_DAT_W-1:0] i_data,
    output flc_pkg::t_cfg                      o_cfg
);
    import flc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval  <= IVL_RESET;
            r_cfg.threshold <= THR_RESET;
        end else if (i_wr) begin
            unique case (t_cfg_reg'(i_index))
                REG_INTERVAL:  r_cfg.interval  <= i_data[IVL_W-1:0];
                REG_THRESHOLD: r_cfg.threshold <= i_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/flc_scale.sv */
// ----------------------------------------------------------------------------
// flc_scale
// Input stage: drops the low sample bits, clamps the level and scales it to
// percent, then registers the word.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_scale (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire logic                       i_adv,
    input  wire logic [flc_pkg::RAW_W-1:0]  i_raw_sample,
    input  wire logic [flc_pkg::TIME_W-1:0] i_now_us,
    output logic                            o_valid,
    output flc_pkg::t_s1_word               o_word
);
    import flc_pkg::*;

    logic [LEVEL_W-1:0]    level;
    logic [PCT_PROD_W-1:0] prod;
    logic                  r_valid;
    t_s1_word              r_word;
    t_s1_word              n_word;

    assign level = clamp_level(i_raw_sample[LEVEL_SHIFT +: LEVEL_W]);
    assign prod  = PCT_PROD_W'(level) * PCT_PROD_W'(PCT_RECIP);

    always_comb begin
        n_word.now_us  = i_now_us;
        n_word.level   = level;
        n_word.percent = prod[PCT_SHIFT +: PCT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

/* rtl/flc_decide.sv */
// ----------------------------------------------------------------------------
// flc_decide
// Decision stage: interval check, jitter filter, change detection, state
// update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_decide (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire flc_pkg::t_s1_word       i_word,
    input  wire flc_pkg::t_cfg           i_cfg,
    input  wire logic                    i_out_ready,
    output logic                         o_adv,
    output logic                         o_out_valid,
    output logic [flc_pkg::PCT_W-1:0]    o_fader_percent
);
    import flc_pkg::*;

    logic [TIME_W-1:0]  r_last_time;
    logic [LEVEL_W-1:0] r_held;
    logic [PCT_W-1:0]   r_last_pct;
    logic               r_out_valid;
    logic [PCT_W-1:0]   r_out_pct;

    logic [TIME_W-1:0]  elapsed;
    logic [LEVEL_W-1:0] diff;
    logic               adv;
    logic               process;
    logic               due;
    logic               moved;
    logic               emit;

    assign adv     = !r_out_valid || i_out_ready;
    assign process = i_valid && adv;
    assign elapsed = i_word.now_us - r_last_time;
    assign due     = elapsed > TIME_W'(i_cfg.interval);
    assign diff    = (i_word.level > r_held) ? (i_word.level - r_held)
                                             : (r_held - i_word.level);
    assign moved   = diff > LEVEL_W'(i_cfg.threshold);
    assign emit    = due && moved && (i_word.percent != r_last_pct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_held      <= '0;
            r_last_pct  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (process && due) begin
                r_last_time <= i_word.now_us;
                if (moved) begin
                    r_held <= i_word.level;
                end
                if (emit) begin
                    r_last_pct <= i_word.percent;
                end
            end
            if (process && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && emit) begin
            r_out_pct <= i_word.percent;
        end
    end

    assign o_adv           = adv;
    assign o_out_valid     = r_out_valid;
    assign o_fader_percent = r_out_pct;

    // held level is zero only before the first accepted move
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held == '0 || (r_held >= LEVEL_MIN && r_held <= LEVEL_MAX))
        else $error("held level outside clamp range");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_pct <= PCT_MAX)
        else $error("percent above full scale");

    a_emit_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && emit |=> r_out_valid && r_out_pct == r_last_pct)
        else $error("sent percent and last percent disagree");

    a_emit_needs_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(process && due && moved))
        else $error("result without an evaluated move");

endmodule

`default_nettype wire

/* rtl/fader_level_conditioner.sv */
// ----------------------------------------------------------------------------
// fader_level_conditioner
// Fader poll conditioner: interval gating, 10-bit clamp, jitter filter and
// percent output on change.
// ----------------------------------------------------------------------------
// One sample word is taken every clock cycle. A word passes through two
// registers: the input stage clamps the level and scales it to percent, the
// decision stage checks the elapsed time, filters jitter, updates the held
// state and loads the output register with the percent word. Only
// back-pressure on the output stalls the input, and only when the output
// register is full and not being read. Register writes are taken in any
// cycle and should be made while idle.
`default_nettype none

module fader_level_conditioner (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    flc_in_if.sink     i_in,
    flc_out_if.source  o_out,
    flc_cfg_if.sink    i_cfg
);
    import flc_pkg::*;

    t_cfg     cfg;
    t_s1_word s1_word;
    logic     s1_valid;
    logic     adv;
    logic     in_take;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !s1_valid || adv;
    assign in_take     = i_in.valid && i_in.ready;

    flc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    flc_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_take),
        .i_adv        (adv),
        .i_raw_sample (i_in.raw_sample),
        .i_now_us     (i_in.now_us),
        .o_valid      (s1_valid),
        .o_word       (s1_word)
    );

    flc_decide u_decide (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s1_valid),
        .i_word          (s1_word),
        .i_cfg           (cfg),
        .i_out_ready     (o_out.ready),
        .o_adv           (adv),
        .o_out_valid     (o_out.valid),
        .o_fader_percent (o_out.fader_percent)
    );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fader level conditioner. Poll words are queued
// by the stimulus process and driven with random gaps. Each accepted poll is
// run through a local model of the interval gate, clamp, jitter filter and
// percent scaling, and the percent words the block emits are compared in
// order against the model. Register settings change between idle phases,
// the extremes included.
// ----------------------------------------------------------------------------

module tb_top;

    import flc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned IDLE_SPAN   = 6;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_POLLS = 215;

    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic [TIME_W-1:0] stamp;
    } t_poll;

    logic clk = 1'b0;
    logic rst_n;

    flc_in_if  in_if ();
    flc_out_if out_if ();
    flc_cfg_if cfg_if ();

    fader_level_conditioner i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    t_poll            polls_pending [$];
    logic [PCT_W-1:0] pct_expected  [$];

    logic [IVL_W-1:0]   gate_interval = IVL_RESET;
    logic [THR_W-1:0]   jitter_limit  = THR_RESET;
    logic [TIME_W-1:0]  eval_stamp    = '0;
    logic [LEVEL_W-1:0] level_held    = '0;
    logic [PCT_W-1:0]   pct_sent      = '0;

    logic        in_took  = 1'b0;
    logic        out_took = 1'b0;
    logic        cfg_took = 1'b0;
    int unsigned idle_run = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;

    int unsigned in_gap   = 0;
    int unsigned in_calm  = 0;
    int unsigned out_hold = 0;
    int unsigned out_calm = 0;

    logic [RAW_W-1:0]  last_raw   = '0;
    logic [TIME_W-1:0] last_stamp = '0;

    task automatic report_mismatch(input string msg);
        if (fail_count < 200) begin
            $display("ERROR @%0d: %s", cycle_count, msg);
        end
        fail_count++;
    endtask

    task automatic draw_wait(inout int unsigned calm, output int unsigned cycles);
        if (calm != 0) begin
            calm   = calm - 1;
            cycles = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            calm   = $urandom_range(10, 60);
            cycles = 0;
        end else begin
            cycles = $urandom_range(0, 11);
        end
    endtask

    task automatic predict_percent(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0]  elapsed;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] lvl_gap;
        int unsigned        scaled;
        logic [PCT_W-1:0]   pct;
        elapsed = stamp - eval_stamp;
        if (elapsed > gate_interval) begin
            level = raw[RAW_W-1:LEVEL_SHIFT];
            if (level < LEVEL_MIN) begin
                level = LEVEL_MIN;
            end else if (level > LEVEL_MAX) begin
                level = LEVEL_MAX;
            end
            lvl_gap = (level > level_held) ? level - level_held : level_held - level;
            if (lvl_gap > jitter_limit) begin
                level_held = level;
                scaled     = level * PCT_MAX / LEVEL_MAX;
                pct        = scaled[PCT_W-1:0];
                if (pct != pct_sent) begin
                    pct_sent = pct;
                    pct_expected.push_back(pct);
                end
            end
            eval_stamp = stamp;
        end
    endtask

    task automatic push_poll(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] stamp);
        t_poll p;
        p.raw   = raw;
        p.stamp = stamp;
        polls_pending.push_back(p);
        last_raw   = raw;
        last_stamp = stamp;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(negedge clk); while (!cfg_took);
        cfg_if.valid <= 1'b0;
    endtask

    always @(negedge clk) begin : poll_driver
        t_poll       nxt;
        int unsigned n;
        if (!in_if.valid || in_took) begin
            if (in_gap != 0) begin
                in_gap      <= in_gap - 1;
                in_if.valid <= 1'b0;
            end else if (polls_pending.size() != 0) begin
                nxt = polls_pending.pop_front();
                in_if.raw_sample <= nxt.raw;
                in_if.now_us     <= nxt.stamp;
                in_if.valid      <= 1'b1;
                draw_wait(in_calm, n);
                in_gap <= n;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin : percent_sink
        int unsigned n;
        if (out_took) begin
            draw_wait(out_calm, n);
            out_hold     <= n;
            out_if.ready <= (n == 0);
        end else if (out_hold != 0) begin
            if (out_if.valid) begin
                out_hold     <= out_hold - 1;
                out_if.ready <= (out_hold == 1);
            end
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : percent_check
        logic [PCT_W-1:0] want;
        in_took  <= rst_n && in_if.valid && in_if.ready;
        out_took <= rst_n && out_if.valid && out_if.ready;
        cfg_took <= rst_n && cfg_if.valid && cfg_if.ready;
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pct_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected percent word %0d",
                                              out_if.fader_percent));
                end else begin
                    want = pct_expected.pop_front();
                    if (out_if.fader_percent !== want) begin
                        report_mismatch($sformatf("percent %0d, expected %0d",
                                                  out_if.fader_percent, want));
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_INTERVAL: begin
                        gate_interval = cfg_if.data[IVL_W-1:0];
                    end
                    REG_THRESHOLD: begin
                        jitter_limit = cfg_if.data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                predict_percent(in_if.raw_sample, in_if.now_us);
            end
        end
        if (polls_pending.size() == 0 && !in_if.valid && !cfg_if.valid
                && pct_expected.size() == 0) begin
            idle_run <= idle_run + 1;
        end else begin
            idle_run <= 0;
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned           ph;
        int unsigned           k;
        int unsigned           ivl;
        int unsigned           thr;
        int unsigned           step;
        int unsigned           pick;
        int                    delta;
        int                    tmp;
        logic [RAW_W-1:0]      raw;
        logic [CFG_DAT_W-1:0]  thr_word;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.raw_sample = '0;
        in_if.now_us     = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_INTERVAL;
        cfg_if.data      = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: boundary, restart, jitter, unchanged percent, wrap
        push_poll(16'hFFFF, 32'd0);
        push_poll(16'h0000, 32'd10000);
        push_poll(16'h0000, 32'd10001);
        push_poll(16'hFFFF, 32'd20002);
        push_poll(16'hFFFF, 32'd30003);
        push_poll(16'h0000, 32'd40003);
        push_poll(16'h0000, 32'd40004);
        push_poll(16'h0300, 32'd50005);
        push_poll(16'h037F, 32'd60006);
        push_poll(16'h0480, 32'd70007);
        push_poll(16'h7FFF, 32'd80008);
        push_poll(16'hFFC0, 32'hFFFF_FFF0);
        push_poll(16'h8000, 32'h0000_2000);
        push_poll(16'h8000, 32'h0000_2720);
        push_poll(16'h01FF, 32'h0000_4E31);
        push_poll(16'hFE3F, 32'h8000_0000);
        push_poll(16'h0200, 32'hFFFF_FFFF);
        push_poll(16'h5555, 32'h7FFF_FFFF);
        push_poll(16'hAAAA, 32'h0000_0000);

        for (ph = 0; ph < PHASES; ph++) begin
            while (polls_pending.size() != 0 || idle_run < IDLE_SPAN) @(negedge clk);
            case (ph)
                0: begin ivl = IVL_RESET; thr = THR_RESET; end
                1: begin ivl = 0;         thr = 0;         end
                2: begin ivl = 1;         thr = 63;        end
                3: begin ivl = 20'hFFFFF; thr = 1;         end
                4: begin ivl = 1000000;   thr = 32;        end
                5: begin ivl = 50;        thr = 7;         end
                default: begin
                    ivl = $urandom_range(0, 20'hFFFFF);
                    thr = $urandom_range(0, 63);
                end
            endcase
            thr_word = CFG_DAT_W'($urandom);
            thr_word[THR_W-1:0] = THR_W'(thr);
            write_reg(REG_INTERVAL, CFG_DAT_W'(ivl));
            write_reg(REG_THRESHOLD, thr_word);
            @(posedge clk);
            if ($urandom_range(0, 2) == 0) begin
                last_stamp = 32'hFFFF_FFFF - $urandom_range(0, 3 * ivl + 100);
            end
            for (k = 0; k < PHASE_POLLS; k++) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    step = ivl + $urandom_range(1, 40);
                end else if (pick < 14) begin
                    step = ivl + $urandom_range(0, 1);
                end else if (pick < 17) begin
                    step = $urandom_range(0, ivl);
                end else if (pick < 19) begin
                    step = $urandom;
                end else begin
                    step = 0;
                end
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    // small move around the last level, straddling the jitter limit
                    delta = int'($urandom_range(0, 2 * thr + 6)) - int'(thr) - 3;
                    tmp   = int'(last_raw) + delta * 64;
                    if (tmp < 0) tmp = 0;
                    if (tmp > 65535) tmp = 65535;
                    raw = {tmp[15:6], 6'($urandom)};
                end else if (pick < 9) begin
                    raw = RAW_W'($urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       raw = 16'h0000;
                        1:       raw = 16'hFFFF;
                        2:       raw = 16'h01FF;
                        default: raw = 16'hFE00;
                    endcase
                end
                push_poll(raw, last_stamp + step);
            end
        end

        while (polls_pending.size() != 0 || idle_run < IDLE_SPAN + 2) @(negedge clk);
        if (fail_count == 0 && pct_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
